[rtl/mbq_pkg.sv]
`default_nettype none

package mbq_pkg;

	// channel count and derived index width
	localparam int CHANNELS = 8;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// fixed-point formats
	localparam int COEF_W = 32;
	localparam int SMP_W  = 24;
	localparam int STATE_W = 32;
	localparam int FRAC   = 30;
	localparam int PROD_W = COEF_W + SMP_W;
	localparam int RND_W  = PROD_W - FRAC;
	localparam int ACC_W  = STATE_W + 2;

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FRAC - 1));

	localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'sd8388607);
	localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-64'sd8388608);
	localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] S_MIN = ACC_W'(-64'sd2147483648);

	// register map
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [2:0] REG_B0 = 3'd0;
	localparam logic [2:0] REG_B1 = 3'd1;
	localparam logic [2:0] REG_B2 = 3'd2;
	localparam logic [2:0] REG_A1 = 3'd3;
	localparam logic [2:0] REG_A2 = 3'd4;

	localparam logic signed [COEF_W-1:0] COEF_B0_RST = 32'sh4000_0000;

	typedef struct packed {
		logic [2:0]              chan;
		logic signed [SMP_W-1:0] sample_in;
		logic                    block_end;
	} in_word_t;

	typedef struct packed {
		logic [2:0]              chan_out;
		logic signed [SMP_W-1:0] sample_out;
		logic                    clipped;
		logic                    block_end_out;
	} out_word_t;

	// microcode
	typedef enum logic [2:0] {
		ST_MUL_B0X,
		ST_Y,
		ST_N1_INIT,
		ST_N2_INIT,
		ST_N1_FIN,
		ST_N2_FIN
	} step_t;

	typedef enum logic [2:0] {
		COEF_B0,
		COEF_B1,
		COEF_B2,
		COEF_A1,
		COEF_A2
	} coef_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_Y,
		ACC_N1_INIT,
		ACC_N2_INIT,
		ACC_N1_FIN,
		ACC_N2_FIN
	} acc_op_t;

	typedef enum logic {
		SEQ_NEXT,
		SEQ_END
	} seq_t;

	typedef struct packed {
		logic      mul_en;
		coef_sel_t coef_sel;
		logic      op_y;
		acc_op_t   acc_op;
		seq_t      seq;
	} cw_t;

	// program: multiply issued in a step is consumed by the next step's acc op
	function automatic cw_t ucode(input step_t s);
		cw_t cw;
		cw = '{mul_en: 1'b0, coef_sel: COEF_A2, op_y: 1'b0, acc_op: ACC_NONE, seq: SEQ_END};
		unique case (s)
			ST_MUL_B0X: cw = '{1'b1, COEF_B0, 1'b0, ACC_NONE,    SEQ_NEXT};
			ST_Y:       cw = '{1'b1, COEF_B1, 1'b0, ACC_Y,       SEQ_NEXT};
			ST_N1_INIT: cw = '{1'b1, COEF_B2, 1'b0, ACC_N1_INIT, SEQ_NEXT};
			ST_N2_INIT: cw = '{1'b1, COEF_A1, 1'b1, ACC_N2_INIT, SEQ_NEXT};
			ST_N1_FIN:  cw = '{1'b1, COEF_A2, 1'b1, ACC_N1_FIN,  SEQ_NEXT};
			ST_N2_FIN:  cw = '{1'b0, COEF_A2, 1'b1, ACC_N2_FIN,  SEQ_END};
			default:    cw = '{1'b0, COEF_A2, 1'b0, ACC_NONE,    SEQ_END};
		endcase
		return cw;
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp(
		input logic signed [ACC_W-1:0] v,
		input logic signed [ACC_W-1:0] lo,
		input logic signed [ACC_W-1:0] hi
	);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end
		return r;
	endfunction

	function automatic logic outside_rng(
		input logic signed [ACC_W-1:0] v,
		input logic signed [ACC_W-1:0] lo,
		input logic signed [ACC_W-1:0] hi
	);
		return (v > hi) || (v < lo);
	endfunction

endpackage

`default_nettype wire

[rtl/multichannel_biquad_filter.sv]
`default_nettype none

// channel  | valid         | stall         | word                       | notes
// ---------+---------------+---------------+----------------------------+---------------------
// sample   | sample_valid  | sample_stall  | sample_word (in_word_t)    | chan, sample, marker
// result   | result_valid  | result_stall  | result_word (out_word_t)   | one word per sample
// config   | psel/penable  | (pready = 1)  | paddr/pwdata/prdata        | five Q2.30 coefs
//
// one sample runs through the microcode steps on a single shared 32x24 multiplier
// the next sample is taken on the edge that finishes the current one
// a stalled result register holds the last step until the result register can take the word
// reset clears coefficients to a unity pass-through and all channel delay words to zero
// a channel number at or above the channel count gives a zero sample and leaves state alone

module multichannel_biquad_filter
	import mbq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire in_word_t          sample_word,

	output logic                   result_valid,
	input  wire logic              result_stall,
	output out_word_t              result_word,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	// coefficient registers
	logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

	// per-channel delay words
	logic signed [STATE_W-1:0] delay_one_q [CHANNELS];
	logic signed [STATE_W-1:0] delay_two_q [CHANNELS];

	// sequencer
	logic  busy_q;
	step_t step_q;
	cw_t   cw;

	// item registers
	logic [2:0]              chan_q;
	logic [CH_W-1:0]         chan_idx_q;
	logic                    in_range_q;
	logic                    be_q;
	logic signed [SMP_W-1:0] x_q;
	logic signed [SMP_W-1:0] y_q;
	logic                    clip_q;

	// datapath
	logic signed [PROD_W-1:0] mul_s1;
	logic signed [PROD_W-1:0] rsum;
	logic signed [RND_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  rx;
	logic signed [ACC_W-1:0]  acc1_q, acc2_q;
	logic signed [ACC_W-1:0]  ysum, n1sum, n2sum;
	logic signed [COEF_W-1:0] coef_m;
	logic signed [SMP_W-1:0]  oper_m;

	logic slot_free;
	logic finish;
	logic accept;
	logic cfg_wr;
	logic n2_clip;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_B0_RST;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
		end else if (cfg_wr) begin
			// writes above the last register fall through
			unique case (paddr[4:2])
				REG_B0:  b0_q <= pwdata;
				REG_B1:  b1_q <= pwdata;
				REG_B2:  b2_q <= pwdata;
				REG_A1:  a1_q <= pwdata;
				REG_A2:  a2_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_B0:  prdata = b0_q;
			REG_B1:  prdata = b1_q;
			REG_B2:  prdata = b2_q;
			REG_A1:  prdata = a1_q;
			REG_A2:  prdata = a2_q;
			default: prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	assign cw        = ucode(step_q);
	assign slot_free = !result_valid || !result_stall;
	// last step only retires once the result register can take the word
	assign finish    = busy_q && (cw.seq == SEQ_END) && slot_free;
	// a new sample enters on the same edge the previous one retires
	assign sample_stall = busy_q && !finish;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_MUL_B0X;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= ST_MUL_B0X;
		end else if (finish) begin
			busy_q <= 1'b0;
			step_q <= ST_MUL_B0X;
		end else if (busy_q && cw.seq == SEQ_NEXT) begin
			step_q <= step_t'(step_q + 3'd1);
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q     <= sample_word.chan;
			chan_idx_q <= CH_W'(sample_word.chan);
			in_range_q <= 32'(sample_word.chan) < 32'(CHANNELS);
			be_q       <= sample_word.block_end;
			x_q        <= sample_word.sample_in;
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		unique case (cw.coef_sel)
			COEF_B0: coef_m = b0_q;
			COEF_B1: coef_m = b1_q;
			COEF_B2: coef_m = b2_q;
			COEF_A1: coef_m = a1_q;
			COEF_A2: coef_m = a2_q;
			default: coef_m = a2_q;
		endcase
		oper_m = cw.op_y ? y_q : x_q;
	end

	always_ff @(posedge clk) begin
		if (busy_q && cw.mul_en) begin
			mul_s1 <= coef_m * oper_m;
		end
	end

	// round half up, then drop the 30 fraction bits
	assign rsum = mul_s1 + RND_HALF;
	assign rnd  = rsum[PROD_W-1:FRAC];
	assign rx   = ACC_W'(rnd);

	assign ysum  = rx + ACC_W'(delay_one_q[chan_idx_q]);
	assign n1sum = acc1_q - rx;
	assign n2sum = acc2_q - rx;
	assign n2_clip = outside_rng(n2sum, S_MIN, S_MAX);

	// ---------------- accumulate and state update ----------------
	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (cw.acc_op)
				ACC_Y:       y_q    <= SMP_W'(clamp(ysum, Y_MIN, Y_MAX));
				ACC_N1_INIT: acc1_q <= rx + ACC_W'(delay_two_q[chan_idx_q]);
				ACC_N2_INIT: acc2_q <= rx;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (accept) begin
			clip_q <= 1'b0;
		end else if (busy_q && cw.acc_op == ACC_Y) begin
			clip_q <= clip_q | outside_rng(ysum, Y_MIN, Y_MAX);
		end else if (busy_q && cw.acc_op == ACC_N1_FIN) begin
			clip_q <= clip_q | outside_rng(n1sum, S_MIN, S_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
		end else if (busy_q && in_range_q) begin
			if (cw.acc_op == ACC_N1_FIN) begin
				delay_one_q[chan_idx_q] <= STATE_W'(clamp(n1sum, S_MIN, S_MAX));
			end
			if (cw.acc_op == ACC_N2_FIN && finish) begin
				delay_two_q[chan_idx_q] <= STATE_W'(clamp(n2sum, S_MIN, S_MAX));
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (finish) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_word.chan_out      <= chan_q;
			result_word.sample_out    <= in_range_q ? y_q : '0;
			result_word.clipped       <= in_range_q && (clip_q || n2_clip);
			result_word.block_end_out <= be_q;
		end
	end

	// ---------------- checks ----------------
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && step_q == ST_MUL_B0X)
		else $error("accepted sample did not start the program");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q == ST_MUL_B0X || step_q == ST_Y || step_q == ST_N1_INIT ||
			step_q == ST_N2_INIT || step_q == ST_N1_FIN || step_q == ST_N2_FIN))
		else $error("step counter left the program");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result_valid)
		else $error("retired sample gave no result word");

	a_rise_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(finish))
		else $error("result word appeared without a retiring sample");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cw.seq == SEQ_END && !slot_free) |=> busy_q && step_q == ST_N2_FIN)
		else $error("last step advanced into a full result register");

endmodule

`default_nettype wire

[tb/tb_multichannel_biquad_filter.sv]
`default_nettype none

module tb_multichannel_biquad_filter
	import mbq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// coefficient count follows the register map, plus one address that decodes to nothing
	localparam int         N_COEFS    = int'(REG_A2) + 1;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	localparam int RAND_PHASES     = 12;
	localparam int WORDS_PER_PHASE = 95;
	localparam int REPORT_LIMIT    = 10;

	// pacing of the two streaming sides
	typedef enum int {
		PACE_FREE,
		PACE_SRC_IDLE,
		PACE_SINK_STALL,
		PACE_BOTH
	} pace_t;

	// directed stimulus row: coefficient set, input word, and a hand-written answer where obvious
	typedef struct packed {
		logic [1:0]        coef_set;
		logic [2:0]        chan;
		logic signed [23:0] smp;
		logic              blk;
		logic              typed;
		logic signed [23:0] want;
		logic              want_clip;
	} probe_row_t;

	// set 0 is the reset pass-through, 1 and 2 are the gain extremes, 3 is a resonant low-pass
	localparam logic signed [COEF_W-1:0] PROBE_COEFS [4][N_COEFS] = '{
		'{32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{32'sh7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{32'sh8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
		'{32'sh0400_0000, 32'sh0800_0000, 32'sh0400_0000, -32'sd1717986918, 32'sd751619277}
	};

	localparam int N_PROBES = 25;
	localparam probe_row_t PROBES [N_PROBES] = '{
		// unity gain: output equals input, both ends of the range and alternating bits
		'{2'd0, 3'd0, 24'sd0,       1'b0, 1'b1, 24'sd0,       1'b0},
		'{2'd0, 3'd7, 24'sd8388607, 1'b1, 1'b1, 24'sd8388607, 1'b0},
		'{2'd0, 3'd3, 24'sh800000,  1'b0, 1'b1, 24'sh800000,  1'b0},
		'{2'd0, 3'd5, 24'sd1,       1'b1, 1'b1, 24'sd1,       1'b0},
		'{2'd0, 3'd2, -24'sd1,      1'b0, 1'b1, -24'sd1,      1'b0},
		'{2'd0, 3'd1, 24'sh555555,  1'b0, 1'b1, 24'sh555555,  1'b0},
		'{2'd0, 3'd6, 24'shAAAAAA,  1'b1, 1'b1, 24'shAAAAAA,  1'b0},
		'{2'd0, 3'd4, 24'sd12345,   1'b1, 1'b1, 24'sd12345,   1'b0},
		// gain just under +2: clips at both rails, small values round back to exact
		'{2'd1, 3'd0, 24'sd8388607, 1'b0, 1'b1, 24'sd8388607, 1'b1},
		'{2'd1, 3'd7, 24'sh800000,  1'b1, 1'b1, 24'sh800000,  1'b1},
		'{2'd1, 3'd1, 24'sd1000,    1'b0, 1'b1, 24'sd2000,    1'b0},
		'{2'd1, 3'd2, 24'sd0,       1'b0, 1'b1, 24'sd0,       1'b0},
		// gain of exactly -2: inverted clipping, and a result that lands on the rail unclipped
		'{2'd2, 3'd3, 24'sd8388607, 1'b0, 1'b1, 24'sh800000,  1'b1},
		'{2'd2, 3'd4, 24'sh800000,  1'b1, 1'b1, 24'sd8388607, 1'b1},
		'{2'd2, 3'd5, 24'shC00000,  1'b0, 1'b1, 24'sd8388607, 1'b1},
		'{2'd2, 3'd6, 24'sh400000,  1'b0, 1'b1, 24'sh800000,  1'b0},
		'{2'd2, 3'd7, -24'sd3,      1'b1, 1'b1, 24'sd6,       1'b0},
		// impulse into a feedback section, interleaved channels keep separate delay words
		'{2'd3, 3'd0, 24'sd1000000, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd0, 24'sd0,       1'b0, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd7, 24'sh800000,  1'b1, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd0, 24'sd0,       1'b0, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd7, 24'sd8388607, 1'b0, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd0, 24'sd0,       1'b1, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd7, 24'sd0,       1'b0, 1'b0, 24'sd0,       1'b0},
		'{2'd3, 3'd0, 24'sd0,       1'b0, 1'b0, 24'sd0,       1'b0}
	};

	// dut signals
	logic                clk = 1'b0;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	in_word_t            sample_word;
	logic                result_valid;
	logic                result_stall = 1'b0;
	out_word_t           result_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// predictor state: shared coefficients and two delay words per channel
	logic signed [COEF_W-1:0]  coef_gain [N_COEFS];
	logic signed [STATE_W-1:0] chan_z1 [CHANNELS] = '{default: '0};
	logic signed [STATE_W-1:0] chan_z2 [CHANNELS] = '{default: '0};

	// filtered words still owed by the dut, oldest first
	out_word_t pending_words [$];

	int    send_gap_pct = 0;
	int    stall_pct    = 0;
	int    failures     = 0;
	int    n_sent       = 0;
	int    n_recv       = 0;
	int    n_clipped    = 0;
	int    n_blk_end    = 0;
	int    n_writes     = 0;
	int    n_settings   = 0;

	multichannel_biquad_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_word  (sample_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	// every failure goes through here, only the first few are printed
	function automatic void flag_error(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endfunction

	// q2.30 product back to sample scale, round half up
	function automatic longint q30_round(input longint p);
		return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint clip_to(input longint v, input int bits, inout logic hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -(longint'(1) <<< (bits - 1));
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// transposed direct form ii, one sample of one channel
	function automatic out_word_t filter_sample(input in_word_t w);
		longint    x;
		longint    y;
		longint    n1;
		longint    n2;
		logic      hit;
		out_word_t r;
		x   = longint'($signed(w.sample_in));
		y   = 0;
		hit = 1'b0;
		if (int'(w.chan) < CHANNELS) begin
			y  = clip_to(q30_round(longint'(coef_gain[REG_B0]) * x)
				+ longint'(chan_z1[w.chan]), SMP_W, hit);
			n1 = q30_round(longint'(coef_gain[REG_B1]) * x)
				- q30_round(longint'(coef_gain[REG_A1]) * y)
				+ longint'(chan_z2[w.chan]);
			n2 = q30_round(longint'(coef_gain[REG_B2]) * x)
				- q30_round(longint'(coef_gain[REG_A2]) * y);
			n1 = clip_to(n1, STATE_W, hit);
			n2 = clip_to(n2, STATE_W, hit);
			chan_z1[w.chan] = n1[STATE_W-1:0];
			chan_z2[w.chan] = n2[STATE_W-1:0];
		end
		r.chan_out      = w.chan;
		r.sample_out    = y[SMP_W-1:0];
		r.clipped       = hit;
		r.block_end_out = w.block_end;
		return r;
	endfunction

	// apb write: setup, access, then idle with psel low so back-to-back calls never collide
	task automatic coef_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx <= REG_A2) begin
			coef_gain[idx] = val;
		end
		n_writes++;
	endtask

	// apb read, prdata taken in the access cycle
	task automatic coef_readback(input logic [2:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== coef_gain[idx]) begin
			flag_error($sformatf("coef register %0d reads %h, expected %h",
				idx, prdata, coef_gain[idx]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one word, optional idle gap first; valid stays up into the next word when no gap
	task automatic send_sample(input in_word_t w, input logic has_typed, input out_word_t typed);
		int        gap;
		out_word_t exp;
		gap = 0;
		while (send_gap_pct != 0 && gap < 60 && int'($urandom_range(0, 99)) < send_gap_pct) begin
			gap++;
		end
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_word  <= w;
		do @(posedge clk); while (sample_stall);
		exp = filter_sample(w);
		if (has_typed) begin
			exp = typed;
		end
		pending_words.push_back(exp);
		n_sent++;
	endtask

	// stop sending and let every owed word come back before touching registers
	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_coefs(input logic signed [COEF_W-1:0] c [N_COEFS]);
		for (int r = REG_B0; r <= REG_A2; r++) begin
			coef_write(3'(r), c[r]);
		end
		// an unmapped address must not disturb any coefficient
		coef_write(REG_UNUSED, {$urandom()});
		for (int r = REG_B0; r <= REG_A2; r++) begin
			coef_readback(3'(r));
		end
		n_settings++;
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		result_stall <= (stall_pct != 0) && (int'($urandom_range(0, 99)) < stall_pct);
	end

	// result checker: each accepted word against the oldest expectation
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_recv++;
			if (result_word.clipped) n_clipped++;
			if (result_word.block_end_out) n_blk_end++;
			if (pending_words.size() == 0) begin
				flag_error($sformatf("unexpected word chan %0d sample %0d clip %0b end %0b",
					result_word.chan_out, result_word.sample_out,
					result_word.clipped, result_word.block_end_out));
			end else begin
				want = pending_words.pop_front();
				if (result_word.chan_out !== want.chan_out
						|| result_word.sample_out !== want.sample_out
						|| result_word.clipped !== want.clipped
						|| result_word.block_end_out !== want.block_end_out) begin
					flag_error($sformatf({"word mismatch: expected chan %0d sample %0d clip %0b ",
						"end %0b, got chan %0d sample %0d clip %0b end %0b"},
						want.chan_out, want.sample_out, want.clipped, want.block_end_out,
						result_word.chan_out, result_word.sample_out,
						result_word.clipped, result_word.block_end_out));
				end
			end
		end
	end

	// main sequence
	initial begin
		in_word_t                 w;
		out_word_t                typed;
		int                       cur_set;
		int                       pick;
		logic [2:0]               focus;
		logic [31:0]              raw;
		logic signed [COEF_W-1:0] phase_coefs [N_COEFS];

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_word  = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		coef_gain    = '{default: '0};
		coef_gain[REG_B0] = COEF_B0_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the coefficient bank
		for (int r = REG_B0; r <= REG_A2; r++) begin
			coef_readback(3'(r));
		end

		// directed part, no idling
		cur_set = 0;
		for (int i = 0; i < N_PROBES; i++) begin
			if (int'(PROBES[i].coef_set) != cur_set) begin
				settle();
				cur_set = int'(PROBES[i].coef_set);
				load_coefs(PROBE_COEFS[cur_set]);
			end
			w.chan          = PROBES[i].chan;
			w.sample_in     = PROBES[i].smp;
			w.block_end     = PROBES[i].blk;
			typed.chan_out      = PROBES[i].chan;
			typed.sample_out    = PROBES[i].want;
			typed.clipped       = PROBES[i].want_clip;
			typed.block_end_out = PROBES[i].blk;
			send_sample(w, PROBES[i].typed, typed);
		end

		// random phases: new coefficients and a new pacing each time, drained in between
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			for (int r = REG_B0; r <= REG_A2; r++) begin
				pick = int'($urandom_range(0, 9));
				if (ph == 0 || (ph > 2 && pick == 0)) begin
					phase_coefs[r] = 32'sh7FFF_FFFF;
				end else if (ph == 1 || (ph > 2 && pick == 1)) begin
					phase_coefs[r] = 32'sh8000_0000;
				end else if (ph == 2 || pick == 2) begin
					phase_coefs[r] = 32'sd0;
				end else if (pick < 6) begin
					phase_coefs[r] = $urandom();
				end else begin
					// within +-1.0, where most of the output stays off the rails
					phase_coefs[r] = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
				end
			end
			load_coefs(phase_coefs);

			case (pace_t'(ph % 4))
				PACE_FREE: begin
					send_gap_pct = 0;
					stall_pct    = 0;
				end
				PACE_SRC_IDLE: begin
					send_gap_pct = 85;
					stall_pct    = 0;
				end
				PACE_SINK_STALL: begin
					send_gap_pct = 0;
					stall_pct    = 85;
				end
				default: begin
					send_gap_pct = 13;
					stall_pct    = 13;
				end
			endcase

			focus = 3'($urandom_range(0, 7));
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				raw = $urandom();
				// half the words stay on one channel so its delay words build up
				if ($urandom_range(0, 1) == 0) begin
					w.chan = focus;
				end else begin
					w.chan = raw[26:24];
				end
				if ($urandom_range(0, 15) == 0) begin
					focus = 3'($urandom_range(0, 7));
				end
				pick = int'($urandom_range(0, 9));
				case (pick)
					0: w.sample_in = 24'sd8388607;
					1: w.sample_in = 24'sh800000;
					2: w.sample_in = 24'sd0;
					3, 4: w.sample_in = 24'($signed(raw[8:0]));
					default: w.sample_in = raw[23:0];
				endcase
				w.block_end = ($urandom_range(0, 7) == 0);
				send_sample(w, 1'b0, '0);
			end
		end

		// wait out every owed word plus a margin for anything spurious
		settle();
		send_gap_pct = 0;
		stall_pct    = 0;
		repeat (20) @(posedge clk);

		$display("sent %0d samples under %0d coefficient settings (%0d register writes)",
			n_sent, n_settings, n_writes);
		$display("received %0d words, %0d clipped, %0d block ends, %0d failures",
			n_recv, n_clipped, n_blk_end, failures);
		if (failures == 0 && pending_words.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10ms;
		$display("timeout with %0d words outstanding", pending_words.size());
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[multichannel_biquad_filter.f]
rtl/mbq_pkg.sv
rtl/multichannel_biquad_filter.sv
tb/tb_multichannel_biquad_filter.sv
